@@ rtl/dwepc_pkg.sv @@
// ----------------------------------------------------------------------------
// dwepc_pkg
// Types and constants shared by the two-wheel encoder speed controller.
// ----------------------------------------------------------------------------
package dwepc_pkg;

  localparam int TARGET_W = 16;
  localparam int DRIVE_W  = 16;
  localparam int GAIN_W   = 8;
  localparam int DB_W     = 15;
  localparam int THR_W    = 8;
  // Errors are clamped to this width before the gain multiply. Any error
  // outside it saturates the drive for every nonzero gain.
  localparam int ERR_W    = 17;

  localparam int APB_DW   = 32;
  localparam int APB_AW   = 4;

  // Item commands.
  localparam logic [1:0] CMD_LEFT    = 2'd0;
  localparam logic [1:0] CMD_RIGHT   = 2'd1;
  localparam logic [1:0] CMD_SAMPLE  = 2'd2;
  localparam logic [1:0] CMD_CONTROL = 2'd3;

  // Register indexes.
  localparam logic [1:0] REG_HOLD_GAIN = 2'd0;
  localparam logic [1:0] REG_MOVE_GAIN = 2'd1;
  localparam logic [1:0] REG_DEADBAND  = 2'd2;
  localparam logic [1:0] REG_ACCEL_THR = 2'd3;

  localparam logic [GAIN_W-1:0] HOLD_GAIN_RST = 8'd16;
  localparam logic [GAIN_W-1:0] MOVE_GAIN_RST = 8'd19;
  localparam logic [DB_W-1:0]   DEADBAND_RST  = 15'd28;
  localparam logic [THR_W-1:0]  ACCEL_THR_RST = 8'd2;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic                       dir_bit;
    logic signed [TARGET_W-1:0] left_target;
    logic signed [TARGET_W-1:0] right_target;
  } in_item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
  } out_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] hold_gain;
    logic [GAIN_W-1:0] move_gain;
    logic [DB_W-1:0]   deadband;
    logic [THR_W-1:0]  accel_threshold;
  } cfg_t;

endpackage

@@ rtl/dual_wheel_encoder_p_controller.sv @@
// ----------------------------------------------------------------------------
// dual_wheel_encoder_p_controller
// Two-wheel proportional speed controller fed by encoder pulse items.
// ----------------------------------------------------------------------------
//
//   channel  ports                              direction  notes
//   in       in_valid, in_stall, in_data        in         one item per cycle unless stalled
//   out      out_valid, out_stall, out_data     out        control steps only
//   cfg      psel, penable, pwrite, paddr,      in/out     APB, 4 registers
//            pwdata, prdata, pready
//
// An accepted item sits in the input register, where it updates the
// counters or computes both drives; a control result is loaded into the output
// register as it leaves the input register and can then be taken.
// The sustained rate is one item per clock unless a stalled result holds a control
// step; the gain multiply per wheel sets the cycle time.
// Reset is synchronous and returns counters and registers to their defaults.
// A stalled result holds only a control step waiting in the input register;
// pulse and sample items keep flowing.
//
module dual_wheel_encoder_p_controller
  import dwepc_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,

  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  cfg_t      cfg;
  in_item_t  item_r;
  logic      item_valid_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  logic signed [COUNT_WIDTH-1:0] left_count_r,  left_count_nxt;
  logic signed [COUNT_WIDTH-1:0] right_count_r, right_count_nxt;
  logic signed [COUNT_WIDTH-1:0] left_sampled_r,  left_sampled_nxt;
  logic signed [COUNT_WIDTH-1:0] right_sampled_r, right_sampled_nxt;
  logic signed [COUNT_WIDTH-1:0] left_prev_r,  left_prev_nxt;
  logic signed [COUNT_WIDTH-1:0] right_prev_r, right_prev_nxt;

  logic                       is_ctrl;
  logic                       out_free;
  logic                       item_adv;
  logic                       in_accept;
  logic                       hold;
  logic signed [DRIVE_W-1:0]  left_drive;
  logic signed [DRIVE_W-1:0]  right_drive;

  dwepc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign hold = (item_r.left_target == '0) && (item_r.right_target == '0);

  dwepc_wheel #(.CW(COUNT_WIDTH)) u_left (
    .hold     (hold),
    .target   (item_r.left_target),
    .sampled  (left_sampled_r),
    .previous (left_prev_r),
    .cfg      (cfg),
    .drive    (left_drive)
  );

  dwepc_wheel #(.CW(COUNT_WIDTH)) u_right (
    .hold     (hold),
    .target   (item_r.right_target),
    .sampled  (right_sampled_r),
    .previous (right_prev_r),
    .cfg      (cfg),
    .drive    (right_drive)
  );

  // Only a control step needs the output register; others retire at once.
  assign is_ctrl   = (item_r.cmd == CMD_CONTROL);
  assign out_free  = !out_valid_r || !out_stall;
  assign item_adv  = item_valid_r && (!is_ctrl || out_free);
  assign in_stall  = item_valid_r && !item_adv;
  assign in_accept = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    left_count_nxt    = left_count_r;
    right_count_nxt   = right_count_r;
    left_sampled_nxt  = left_sampled_r;
    right_sampled_nxt = right_sampled_r;
    left_prev_nxt     = left_prev_r;
    right_prev_nxt    = right_prev_r;
    if (item_adv) begin
      unique case (item_r.cmd)
        CMD_LEFT: begin
          // The left encoder counts down when the direction bit is set.
          if (!item_r.dir_bit) begin
            if (left_count_r != CNT_MAX) left_count_nxt = left_count_r + 1'b1;
          end else begin
            if (left_count_r != CNT_MIN) left_count_nxt = left_count_r - 1'b1;
          end
        end
        CMD_RIGHT: begin
          if (item_r.dir_bit) begin
            if (right_count_r != CNT_MAX) right_count_nxt = right_count_r + 1'b1;
          end else begin
            if (right_count_r != CNT_MIN) right_count_nxt = right_count_r - 1'b1;
          end
        end
        CMD_SAMPLE: begin
          left_sampled_nxt  = left_count_r;
          right_sampled_nxt = right_count_r;
          left_count_nxt    = '0;
          right_count_nxt   = '0;
        end
        CMD_CONTROL: begin
          left_prev_nxt  = left_sampled_r;
          right_prev_nxt = right_sampled_r;
        end
        default: begin
          left_count_nxt = left_count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r    <= 1'b0;
      out_valid_r     <= 1'b0;
      left_count_r    <= '0;
      right_count_r   <= '0;
      left_sampled_r  <= '0;
      right_sampled_r <= '0;
      left_prev_r     <= '0;
      right_prev_r    <= '0;
    end else begin
      left_count_r    <= left_count_nxt;
      right_count_r   <= right_count_nxt;
      left_sampled_r  <= left_sampled_nxt;
      right_sampled_r <= right_sampled_nxt;
      left_prev_r     <= left_prev_nxt;
      right_prev_r    <= right_prev_nxt;
      if (in_accept) begin
        item_valid_r <= 1'b1;
      end else if (item_adv) begin
        item_valid_r <= 1'b0;
      end
      if (item_adv && is_ctrl) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
    if (item_adv && is_ctrl) begin
      out_data_r.left_drive  <= left_drive;
      out_data_r.right_drive <= right_drive;
    end
  end

  // A pulse or sample item in the input register never holds off new items.
  a_no_stall_for_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && !is_ctrl) |-> !in_stall)
    else $error("input stalled behind a pulse or sample item");

  // A control step waits while a previous result is still stalled.
  a_ctrl_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && is_ctrl && out_valid && out_stall) |=>
      (item_valid_r && is_ctrl && $stable(left_prev_r) && $stable(right_prev_r)))
    else $error("control step left the input register while output was blocked");

  // Sampling clears both pulse counters.
  a_sample_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (item_adv && item_r.cmd == CMD_SAMPLE) |=>
      (left_count_r == '0 && right_count_r == '0))
    else $error("pulse counters not cleared by a sample item");

  // A new result comes only from a control step leaving the input register.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid && out_stall)) |->
      $past(item_valid_r && is_ctrl))
    else $error("result produced without a control step");

endmodule

@@ rtl/dwepc_regs.sv @@
// ----------------------------------------------------------------------------
// dwepc_regs
// APB register bank holding the gains, deadband and acceleration threshold.
// ----------------------------------------------------------------------------
module dwepc_regs
  import dwepc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_HOLD_GAIN: cfg_nxt.hold_gain       = pwdata[GAIN_W-1:0];
        REG_MOVE_GAIN: cfg_nxt.move_gain       = pwdata[GAIN_W-1:0];
        REG_DEADBAND:  cfg_nxt.deadband        = pwdata[DB_W-1:0];
        REG_ACCEL_THR: cfg_nxt.accel_threshold = pwdata[THR_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HOLD_GAIN: prdata = APB_DW'(cfg_r.hold_gain);
      REG_MOVE_GAIN: prdata = APB_DW'(cfg_r.move_gain);
      REG_DEADBAND:  prdata = APB_DW'(cfg_r.deadband);
      REG_ACCEL_THR: prdata = APB_DW'(cfg_r.accel_threshold);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_gain       <= HOLD_GAIN_RST;
      cfg_r.move_gain       <= MOVE_GAIN_RST;
      cfg_r.deadband        <= DEADBAND_RST;
      cfg_r.accel_threshold <= ACCEL_THR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/dwepc_wheel.sv @@
// ----------------------------------------------------------------------------
// dwepc_wheel
// Proportional drive for one wheel: error, deadband or acceleration scaling,
// gain multiply and 16-bit saturation.
// ----------------------------------------------------------------------------
module dwepc_wheel
  import dwepc_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic                       hold,
  input  logic signed [TARGET_W-1:0] target,
  input  logic signed [CW-1:0]       sampled,
  input  logic signed [CW-1:0]       previous,
  input  cfg_t                       cfg,
  output logic signed [DRIVE_W-1:0]  drive
);

  localparam int EW     = ((CW + 2 > TARGET_W) ? CW + 2 : TARGET_W) + 1;
  localparam int DW     = CW + 2;
  localparam int PROD_W = GAIN_W + 1 + ERR_W;

  localparam logic signed [EW-1:0]     E_HI = EW'(65535);
  localparam logic signed [EW-1:0]     E_LO = -EW'(65536);
  localparam logic signed [PROD_W-1:0] P_HI = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] P_LO = -PROD_W'(32768);

  logic signed [EW-1:0]     quad;
  logic signed [EW-1:0]     db_ext;
  logic signed [EW-1:0]     e_hold;
  logic signed [EW-1:0]     e_hold_sel;
  logic signed [EW-1:0]     e_move;
  logic signed [EW-1:0]     e_move_div;
  logic signed [EW-1:0]     e_move_sel;
  logic signed [EW-1:0]     e_sel;
  logic signed [ERR_W-1:0]  e_clamp;
  logic signed [DW-1:0]     rise;
  logic signed [DW-1:0]     thr_ext;
  logic                     in_band;
  logic                     round_up;
  logic [GAIN_W-1:0]        gain;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    quad   = EW'(sampled) <<< 2;
    db_ext = EW'($signed({1'b0, cfg.deadband}));

    // Hold error is -4*count, so dividing it by four is exactly -count.
    e_hold     = -quad;
    in_band    = (e_hold < db_ext) && (e_hold > -db_ext);
    e_hold_sel = in_band ? -EW'(sampled) : e_hold;

    // Divide by eight toward zero: shift, then bump negative inexact values.
    e_move     = EW'(target) - quad;
    round_up   = e_move[EW-1] & (|e_move[2:0]);
    e_move_div = (e_move >>> 3) + EW'($signed({1'b0, round_up}));
    rise       = DW'(sampled) - DW'(previous);
    thr_ext    = DW'($signed({1'b0, cfg.accel_threshold}));
    e_move_sel = (rise >= thr_ext) ? e_move_div : e_move;

    e_sel = hold ? e_hold_sel : e_move_sel;
    gain  = hold ? cfg.hold_gain : cfg.move_gain;

    if (e_sel > E_HI) begin
      e_clamp = ERR_W'(65535);
    end else if (e_sel < E_LO) begin
      e_clamp = -ERR_W'(65536);
    end else begin
      e_clamp = e_sel[ERR_W-1:0];
    end

    prod = $signed({1'b0, gain}) * e_clamp;

    if (prod > P_HI) begin
      drive = DRIVE_W'(32767);
    end else if (prod < P_LO) begin
      drive = -DRIVE_W'(32768);
    end else begin
      drive = prod[DRIVE_W-1:0];
    end
  end

endmodule

@@ tb/sv/dwepc_drive_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwepc_drive_checker
// Watches the item, result and register channels of the two-wheel encoder
// speed controller. It keeps its own copy of the pulse counters, latched
// counts and registers, works out the drive pair of every control step and
// compares each result and each register read against it.
// ----------------------------------------------------------------------------
module dwepc_drive_checker
  import dwepc_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic [APB_DW-1:0] prdata,
  input  logic              pready,
  output int                pending,
  output int                fail_count
);

  localparam longint COUNT_MAX = (longint'(1) << (COUNT_WIDTH - 1)) - 1;
  localparam longint COUNT_MIN = -(longint'(1) << (COUNT_WIDTH - 1));
  localparam longint DRIVE_MAX = (longint'(1) << (DRIVE_W - 1)) - 1;
  localparam longint DRIVE_MIN = -(longint'(1) << (DRIVE_W - 1));

  cfg_t regs;
  logic signed [COUNT_WIDTH-1:0] left_count, right_count;
  logic signed [COUNT_WIDTH-1:0] left_latched, right_latched;
  logic signed [COUNT_WIDTH-1:0] left_prior, right_prior;
  out_item_t expected_drives[$];

  function automatic logic signed [COUNT_WIDTH-1:0] step_count(
    input logic signed [COUNT_WIDTH-1:0] c,
    input logic                          up
  );
    longint v;
    v = c;
    if (up) begin
      v = (v < COUNT_MAX) ? v + 1 : COUNT_MAX;
    end else begin
      v = (v > COUNT_MIN) ? v - 1 : COUNT_MIN;
    end
    return v[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic signed [DRIVE_W-1:0] wheel_drive_value(
    input logic                          hold,
    input logic signed [TARGET_W-1:0]    target,
    input logic signed [COUNT_WIDTH-1:0] latched,
    input logic signed [COUNT_WIDTH-1:0] prior
  );
    longint err, band, thr, gain, s, p, prod;
    s    = latched;
    p    = prior;
    band = regs.deadband;
    thr  = regs.accel_threshold;
    if (hold) begin
      gain = regs.hold_gain;
      err  = -(s * 4);
      // Small position errors are softened inside the deadband.
      if (err < band && err > -band) begin
        err = err / 4;
      end
    end else begin
      gain = regs.move_gain;
      err  = longint'(target) - s * 4;
      // A wheel that is already speeding up gets a gentler push.
      if (s - p >= thr) begin
        err = err / 8;
      end
    end
    prod = gain * err;
    if (prod > DRIVE_MAX) begin
      prod = DRIVE_MAX;
    end else if (prod < DRIVE_MIN) begin
      prod = DRIVE_MIN;
    end
    return prod[DRIVE_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    out_item_t         want;
    out_item_t         drives;
    logic              hold;
    logic [APB_DW-1:0] reg_value;
    if (!rst_n) begin
      regs.hold_gain       = HOLD_GAIN_RST;
      regs.move_gain       = MOVE_GAIN_RST;
      regs.deadband        = DEADBAND_RST;
      regs.accel_threshold = ACCEL_THR_RST;
      left_count    = '0;
      right_count   = '0;
      left_latched  = '0;
      right_latched = '0;
      left_prior    = '0;
      right_prior   = '0;
      expected_drives.delete();
    end else begin
      if (psel && penable && pready && pwrite) begin
        case (paddr[APB_AW-1:2])
          REG_HOLD_GAIN: regs.hold_gain       = pwdata[GAIN_W-1:0];
          REG_MOVE_GAIN: regs.move_gain       = pwdata[GAIN_W-1:0];
          REG_DEADBAND:  regs.deadband        = pwdata[DB_W-1:0];
          REG_ACCEL_THR: regs.accel_threshold = pwdata[THR_W-1:0];
        endcase
      end
      if (psel && penable && pready && !pwrite) begin
        case (paddr[APB_AW-1:2])
          REG_HOLD_GAIN: reg_value = APB_DW'(regs.hold_gain);
          REG_MOVE_GAIN: reg_value = APB_DW'(regs.move_gain);
          REG_DEADBAND:  reg_value = APB_DW'(regs.deadband);
          REG_ACCEL_THR: reg_value = APB_DW'(regs.accel_threshold);
        endcase
        if (prdata !== reg_value) begin
          $error("prdata mismatch at paddr %0h: expected %0h, actual %0h",
                 paddr, reg_value, prdata);
          fail_count++;
        end
      end
      // Results are checked before this edge's item is taken; a result can
      // never belong to the item accepted at the same edge.
      if (out_valid && !out_stall) begin
        if (expected_drives.size() == 0) begin
          $error("unexpected drive result: left_drive %0d, right_drive %0d",
                 out_data.left_drive, out_data.right_drive);
          fail_count++;
        end else begin
          want = expected_drives.pop_front();
          if (out_data.left_drive !== want.left_drive) begin
            $error("left_drive mismatch: expected %0d, actual %0d",
                   want.left_drive, out_data.left_drive);
            fail_count++;
          end
          if (out_data.right_drive !== want.right_drive) begin
            $error("right_drive mismatch: expected %0d, actual %0d",
                   want.right_drive, out_data.right_drive);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_data.cmd)
          CMD_LEFT:  left_count  = step_count(left_count, !in_data.dir_bit);
          CMD_RIGHT: right_count = step_count(right_count, in_data.dir_bit);
          CMD_SAMPLE: begin
            left_latched  = left_count;
            right_latched = right_count;
            left_count    = '0;
            right_count   = '0;
          end
          CMD_CONTROL: begin
            hold = (in_data.left_target == 0) && (in_data.right_target == 0);
            drives.left_drive  = wheel_drive_value(hold, in_data.left_target,
                                                   left_latched, left_prior);
            drives.right_drive = wheel_drive_value(hold, in_data.right_target,
                                                   right_latched, right_prior);
            left_prior  = left_latched;
            right_prior = right_latched;
            expected_drives.push_back(drives);
          end
        endcase
      end
    end
    pending = expected_drives.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the two-wheel encoder speed controller. Runs a short directed
// sequence, then sends random pulse bursts, samples and control steps under
// several register settings, with random gaps on the item side and random
// stalls on the result side; one stretch runs back to back without either.
// ----------------------------------------------------------------------------
module tb_top;
  import dwepc_pkg::*;

  localparam int COUNT_WIDTH = 16;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  in_item_t          in_data     = '0;
  logic              out_stall   = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic              in_stall;
  logic              out_valid;
  out_item_t         out_data;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int   pending;
  int   fail_count;
  int   cycle_count = 0;
  int   stall_run   = 0;
  logic steady_flow = 1'b0;

  dual_wheel_encoder_p_controller #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  dwepc_drive_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) drive_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .pending(pending),
    .fail_count(fail_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("dual_wheel_encoder_p_controller verification failed");
    $finish;
  end

  // Mostly short idle runs, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [TARGET_W-1:0] any_target();
    return TARGET_W'($urandom);
  endfunction

  // The result side stalls in runs of random length and polarity.
  always @(negedge clk) begin
    if (!rst_n || steady_flow) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_run <= idle_len();
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_cmd(input logic [1:0] op, input logic dir,
                          input logic signed [TARGET_W-1:0] lt,
                          input logic signed [TARGET_W-1:0] rt);
    int gap;
    gap = steady_flow ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{cmd: op, dir_bit: dir, left_target: lt, right_target: rt};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic control_step();
    int                         kind;
    logic signed [TARGET_W-1:0] lt, rt;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      lt = '0;
      rt = '0;
    end else if (kind < 6) begin
      lt = any_target();
      rt = any_target();
    end else if (kind < 8) begin
      lt = TARGET_W'($urandom_range(0, 1200) - 600);
      rt = TARGET_W'($urandom_range(0, 1200) - 600);
    end else if (kind == 8) begin
      lt = $urandom_range(0, 1) ? any_target() : '0;
      rt = (lt == 0) ? any_target() : '0;
    end else begin
      lt = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      rt = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
    send_cmd(CMD_CONTROL, 1'($urandom), lt, rt);
  endtask

  // Most traffic is a pulse burst, a sample and one or two control steps;
  // the rest is loose items of any kind.
  task automatic random_traffic(input int n);
    int   sent, burst, k;
    logic left_dir, right_dir;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 7) begin
        burst     = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 16);
        left_dir  = 1'($urandom);
        right_dir = 1'($urandom);
        for (k = 0; k < burst; k++) begin
          if ($urandom_range(0, 1)) begin
            send_cmd(CMD_LEFT, ($urandom_range(0, 7) == 0) ? !left_dir : left_dir,
                     any_target(), any_target());
          end else begin
            send_cmd(CMD_RIGHT, ($urandom_range(0, 7) == 0) ? !right_dir : right_dir,
                     any_target(), any_target());
          end
        end
        send_cmd(CMD_SAMPLE, 1'($urandom), any_target(), any_target());
        k = $urandom_range(1, 2);
        repeat (k) control_step();
        sent += burst + 1 + k;
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) send_cmd(2'($urandom), 1'($urandom), any_target(), any_target());
        sent += k;
      end
    end
  endtask

  // Drives a setup phase, an access phase, then an idle bus; called at a falling edge.
  task automatic reg_access(input logic write, input logic [1:0] idx,
                            input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_back();
    reg_access(1'b0, REG_HOLD_GAIN, '0);
    reg_access(1'b0, REG_MOVE_GAIN, '0);
    reg_access(1'b0, REG_DEADBAND, '0);
    reg_access(1'b0, REG_ACCEL_THR, '0);
  endtask

  task automatic program_regs(input logic [GAIN_W-1:0] hg, input logic [GAIN_W-1:0] mg,
                              input logic [DB_W-1:0] db, input logic [THR_W-1:0] thr);
    reg_access(1'b1, REG_HOLD_GAIN, APB_DW'(hg));
    reg_access(1'b1, REG_MOVE_GAIN, APB_DW'(mg));
    reg_access(1'b1, REG_DEADBAND, APB_DW'(db));
    reg_access(1'b1, REG_ACCEL_THR, APB_DW'(thr));
    read_back();
  endtask

  // Drain every expected result, then give the pipeline time to empty of
  // pulse and sample items that produce none.
  task automatic settle();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (6) @(negedge clk);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    read_back();

    // Hold with nothing sampled yet gives zero drives.
    send_cmd(CMD_CONTROL, 1'b0, '0, '0);
    repeat (7) send_cmd(CMD_LEFT, 1'b0, any_target(), any_target());
    repeat (6) send_cmd(CMD_RIGHT, 1'b1, any_target(), any_target());
    send_cmd(CMD_SAMPLE, 1'b1, any_target(), any_target());
    // First move after the sample sees the count rise and divides by eight.
    send_cmd(CMD_CONTROL, 1'b1, 16'sh7fff, 16'sh8000);
    // Left hold error sits exactly on the deadband edge, right just inside.
    send_cmd(CMD_CONTROL, 1'b0, '0, '0);
    send_cmd(CMD_CONTROL, 1'b1, 16'sh8000, 16'sh7fff);
    send_cmd(CMD_LEFT, 1'b1, any_target(), any_target());
    send_cmd(CMD_RIGHT, 1'b0, any_target(), any_target());
    send_cmd(CMD_SAMPLE, 1'b0, any_target(), any_target());
    send_cmd(CMD_CONTROL, 1'b0, 16'sd1, '0);
    send_cmd(CMD_CONTROL, 1'b1, '0, '0);
    random_traffic(200);

    // Largest settings, first with items back to back and no result stalls.
    settle();
    program_regs(8'hff, 8'hff, 15'h7fff, 8'hff);
    steady_flow = 1'b1;
    random_traffic(100);
    steady_flow = 1'b0;
    random_traffic(100);

    settle();
    program_regs('0, '0, '0, '0);
    random_traffic(100);

    // No deadband, so hold errors are never divided.
    settle();
    program_regs(8'($urandom), 8'($urandom), '0, 8'($urandom_range(0, 8)));
    random_traffic(150);

    settle();
    program_regs(8'($urandom), 8'($urandom), 15'($urandom_range(1, 400)),
                 8'($urandom_range(0, 20)));
    random_traffic(150);

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("dual_wheel_encoder_p_controller verification clean");
    end else begin
      $display("dual_wheel_encoder_p_controller verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dwepc_pkg.sv
rtl/dwepc_regs.sv
rtl/dwepc_wheel.sv
rtl/dual_wheel_encoder_p_controller.sv
tb/sv/dwepc_drive_checker.sv
tb/sv/tb_top.sv
